// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the ordered list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge while the active-low reset is released.
`define OLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that ante at one edge implies cons at the next edge.
`define OLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/olc_pkg.sv =====
// Package with the types and codes of the ordered list block.
`timescale 1ns / 1ps

package olc_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int COUNT_W    = 9;

  localparam logic [2:0] REQ_APPEND       = 3'd0;
  localparam logic [2:0] REQ_READ         = 3'd1;
  localparam logic [2:0] REQ_REMOVE_AT    = 3'd2;
  localparam logic [2:0] REQ_REMOVE_VALUE = 3'd3;
  localparam logic [2:0] REQ_CLEAR        = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  entry_index;
    logic [31:0] entry_value;
  } olc_in_t;

  typedef struct packed {
    logic [31:0]        read_value;
    logic [COUNT_W-1:0] list_count;
    logic [1:0]         status;
  } olc_out_t;

endpackage

// ===== rtl/ordered_list_with_compaction_core.sv =====
// Ordered list of 32-bit words with append, read, remove and compaction requests.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block keeps an ordered list of up to olc_pkg::LIST_DEPTH words in a
// single memory with one write port and one registered read port, plus an
// entry count. Each accepted request produces exactly one result transfer that
// carries the read word (zero unless the request is a read), the entry count
// after the request, and a status code. Requests are handled one at a time:
// in_stall_o stays high from the transfer of a request until its result has
// been placed in the output register, which then waits for the consumer while
// the next request can already be taken. Append, clear, unknown requests and
// out-of-range requests pass through the decode and finish steps, and a read
// adds a read-wait step. Remove-at walks the entries above the index, and
// remove-value walks all entries: a small sequencer reads them through the one
// read port, one entry per cycle, and writes survivors back through the write
// port in the cycle after each read. A result held by a stalled consumer adds
// its wait to the next request. No clearing pass is needed after reset: only
// positions below the count are ever read.
module ordered_list_with_compaction_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  olc_pkg::olc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output olc_pkg::olc_out_t out_data_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_LOOP   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  olc_pkg::olc_in_t req_q, req_d;

  logic [olc_pkg::COUNT_W-1:0] count_q, count_d;
  logic [olc_pkg::COUNT_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [olc_pkg::COUNT_W-1:0] wr_ptr_q, wr_ptr_d;
  logic                        pend_q, pend_d;

  logic [31:0] rd_val_q, rd_val_d;
  logic [1:0]  st_q, st_d;

  logic              out_valid_q, out_valid_d;
  olc_pkg::olc_out_t out_q, out_d;

  // List storage: one write port, one registered read port.
  logic [31:0]                mem_q [olc_pkg::LIST_DEPTH];
  logic                       mem_we;
  logic [olc_pkg::ADDR_W-1:0] mem_waddr;
  logic [31:0]                mem_wdata;
  logic                       mem_re;
  logic [olc_pkg::ADDR_W-1:0] mem_raddr;
  logic [31:0]                mem_rdata_q;

  logic                        in_xfer;
  logic [olc_pkg::COUNT_W-1:0] idx_ext;
  logic                        idx_ok;
  logic                        loop_issue;
  logic                        keep_word;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign idx_ext = olc_pkg::COUNT_W'(req_q.entry_index);
  assign idx_ok  = (idx_ext < count_q);

  // In the walk loop a read is issued while entries remain; the word read in the
  // previous cycle is written back unless it matches the value being removed.
  assign loop_issue = (rd_ptr_q < count_q);
  assign keep_word  = pend_q &&
                      ((req_q.req_type != olc_pkg::REQ_REMOVE_VALUE) ||
                       (mem_rdata_q != req_q.entry_value));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    pend_d      = pend_q;
    rd_val_d    = rd_val_q;
    st_d        = st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr_q[olc_pkg::ADDR_W-1:0];
    mem_wdata   = mem_rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_q[olc_pkg::ADDR_W-1:0];

    // The consumer takes the waiting result.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d    = in_data_i;
          rd_val_d = '0;
          st_d     = olc_pkg::ST_OK;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FINISH;
        unique case (req_q.req_type)
          olc_pkg::REQ_APPEND: begin
            if (count_q == olc_pkg::COUNT_W'(olc_pkg::LIST_DEPTH)) begin
              st_d = olc_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_q[olc_pkg::ADDR_W-1:0];
              mem_wdata = req_q.entry_value;
              count_d   = count_q + 1'b1;
            end
          end
          olc_pkg::REQ_READ: begin
            if (idx_ok) begin
              mem_re    = 1'b1;
              mem_raddr = req_q.entry_index[olc_pkg::ADDR_W-1:0];
              state_d   = S_RDWAIT;
            end else begin
              st_d = olc_pkg::ST_RANGE;
            end
          end
          olc_pkg::REQ_REMOVE_AT: begin
            if (idx_ok) begin
              rd_ptr_d = idx_ext + 1'b1;
              wr_ptr_d = idx_ext;
              pend_d   = 1'b0;
              state_d  = S_LOOP;
            end else begin
              st_d = olc_pkg::ST_RANGE;
            end
          end
          olc_pkg::REQ_REMOVE_VALUE: begin
            rd_ptr_d = '0;
            wr_ptr_d = '0;
            pend_d   = 1'b0;
            state_d  = S_LOOP;
          end
          olc_pkg::REQ_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        rd_val_d = mem_rdata_q;
        state_d  = S_FINISH;
      end
      S_LOOP: begin
        if (loop_issue) begin
          mem_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
        pend_d = loop_issue;
        if (keep_word) begin
          mem_we   = 1'b1;
          wr_ptr_d = wr_ptr_q + 1'b1;
        end
        // Both removals end with the write pointer at the new count.
        if (!loop_issue && !pend_q) begin
          count_d = wr_ptr_q;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.read_value = rd_val_q;
          out_d.list_count = count_q;
          out_d.status     = st_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    rd_val_q <= rd_val_d;
    st_q     <= st_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // The count never grows past the depth of the store.
  `OLC_ASSERT(a_count_bound, clk_i, rst_ni,
              count_q <= olc_pkg::COUNT_W'(olc_pkg::LIST_DEPTH),
              "entry count exceeds list depth")

  // An input transfer always starts the decode step.
  `OLC_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, in_xfer, state_q == S_EXEC,
                   "accepted request did not reach decode")

  // The compaction write pointer never overtakes the read pointer.
  `OLC_ASSERT(a_ptr_order, clk_i, rst_ni,
              (state_q != S_LOOP) || (wr_ptr_q <= rd_ptr_q),
              "write pointer passed read pointer")

  // A result only appears when the sequencer finishes a request.
  `OLC_ASSERT(a_result_src, clk_i, rst_ni,
              !$rose(out_valid_q) || ($past(state_q) == S_FINISH),
              "result became valid outside finish step")

endmodule

// ===== tb/sv/olc_list_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts every result of the ordered list block and compares it.
module olc_list_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_stall_i,
  input  olc_pkg::olc_in_t  req_data_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_stall_i,
  input  olc_pkg::olc_out_t rsp_data_i,
  output int                mismatch_count_o,
  output int                results_pending_o
);
  import olc_pkg::*;

  // Shadow copy of the list contents and its length.
  logic [31:0] stored_words [LIST_DEPTH];
  int          word_count;
  olc_out_t    expected_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  // Applies one request to the shadow list and returns the result it must give.
  function automatic olc_out_t predict_list_result(input olc_in_t rq);
    olc_out_t res;
    int       keep;
    res = '0;
    res.status = ST_OK;
    case (rq.req_type)
      REQ_APPEND: begin
        if (word_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          stored_words[word_count] = rq.entry_value;
          word_count++;
        end
      end
      REQ_READ: begin
        if (int'(rq.entry_index) < word_count) begin
          res.read_value = stored_words[rq.entry_index];
        end else begin
          res.status = ST_RANGE;
        end
      end
      REQ_REMOVE_AT: begin
        if (int'(rq.entry_index) < word_count) begin
          for (int j = int'(rq.entry_index) + 1; j < word_count; j++) begin
            stored_words[j-1] = stored_words[j];
          end
          word_count--;
        end else begin
          res.status = ST_RANGE;
        end
      end
      REQ_REMOVE_VALUE: begin
        keep = 0;
        for (int j = 0; j < word_count; j++) begin
          if (stored_words[j] != rq.entry_value) begin
            stored_words[keep] = stored_words[j];
            keep++;
          end
        end
        word_count = keep;
      end
      REQ_CLEAR: begin
        word_count = 0;
      end
      default: begin
      end
    endcase
    res.list_count = COUNT_W'(word_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    olc_out_t want;
    if (!rst_ni) begin
      word_count = 0;
      expected_results.delete();
      results_pending_o <= 0;
    end else begin
      // Results are checked before new requests are predicted, so a result
      // can never be matched against the request taken at the same edge.
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", rsp_data_i.read_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_data_i.read_value !== want.read_value) begin
            report_mismatch("read_value", rsp_data_i.read_value, want.read_value);
          end
          if (rsp_data_i.list_count !== want.list_count) begin
            report_mismatch("list_count", 32'(rsp_data_i.list_count),
                            32'(want.list_count));
          end
          if (rsp_data_i.status !== want.status) begin
            report_mismatch("status", 32'(rsp_data_i.status), 32'(want.status));
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        expected_results.push_back(predict_list_result(req_data_i));
      end
      results_pending_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/sv/ordered_list_with_compaction_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the ordered list block: clock, reset, stimulus and verdict.
module ordered_list_with_compaction_core_tb;
  import olc_pkg::*;

  localparam int CLK_HALF_NS  = 6;
  localparam int RESET_CYCLES = 10;
  // The slowest legal run stays far below this: every request takes at most
  // a walk over the full list plus the longest gap and stall on each side.
  localparam int CYCLE_LIMIT  = 1000000;
  // Long enough that the output register and the request in flight both fill
  // and the block has to stall its input.
  localparam int HOLD_CYCLES  = 400;
  // A remove-value over a full list is the longest latency of the block.
  localparam int TAIL_CYCLES  = LIST_DEPTH + 16;
  localparam int RANDOM_ITEMS = 100;
  localparam int FILL_APPENDS = LIST_DEPTH + 4;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  olc_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  olc_out_t out_data_o;

  int mismatch_count;
  int results_pending;
  int cycle_count;
  int tx_quiet_left;
  int rx_quiet_left;
  bit rx_hold_req;

  ordered_list_with_compaction_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // The checker sees both channels exactly as the block does and reports back
  // how many results are still owed and how many comparisons failed.
  olc_list_checker list_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_stall_i      (in_stall_o),
    .req_data_i       (in_data_i),
    .rsp_valid_i      (out_valid_o),
    .rsp_stall_i      (out_stall_i),
    .rsp_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .results_pending_o(results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF_NS clk_i = ~clk_i;
  end

  // Idle cycles before the next transfer. Now and then a side enters a quiet
  // stretch of back-to-back transfers so that full-rate behavior is covered too.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = 24;
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Values are drawn mostly from a small pool so that remove-value finds
  // matches, often several of them next to each other.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 3) begin
      return $urandom;
    end
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      default: return 32'h0000_5A5A;
    endcase
  endfunction

  // Indexes lean toward the low end, where a short list actually has entries.
  function automatic logic [7:0] pick_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range(0, 7));
      5, 6, 7: return 8'($urandom_range(0, 63));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Fully random fields, used for the idle payload.
  function automatic olc_in_t any_item();
    olc_in_t rq;
    rq.req_type    = 3'($urandom);
    rq.entry_index = 8'($urandom);
    rq.entry_value = $urandom;
    return rq;
  endfunction

  function automatic olc_in_t make_request(input int append_pct);
    olc_in_t rq;
    int      pick;
    rq.entry_index = pick_index();
    rq.entry_value = pick_value();
    if ($urandom_range(0, 99) < append_pct) begin
      rq.req_type = REQ_APPEND;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        rq.req_type = REQ_READ;
      end else if (pick < 55) begin
        rq.req_type = REQ_REMOVE_AT;
      end else if (pick < 85) begin
        rq.req_type = REQ_REMOVE_VALUE;
      end else if (pick < 91) begin
        rq.req_type = REQ_CLEAR;
      end else begin
        // Codes above clear are not defined and must leave the list alone.
        rq.req_type = REQ_CLEAR + 3'($urandom_range(1, 3));
      end
    end
    return rq;
  endfunction

  // Offers one request after a random gap and returns at the edge where the
  // transfer takes place. A gap of zero keeps valid high across requests, so
  // valid is never dropped and raised again within one time step.
  task automatic send_req(input olc_in_t item);
    int gap;
    gap = draw_gap(tx_quiet_left);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      in_data_i  <= any_item();
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] idx,
                         input logic [31:0] val);
    olc_in_t rq;
    rq.req_type    = op;
    rq.entry_index = idx;
    rq.entry_value = val;
    send_req(rq);
  endtask

  // The pending count is registered, so the loop waits on the clock before it
  // first looks at the count.
  task automatic wait_until_drained();
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  task automatic run_directed();
    // Read and both removals on an empty list.
    send_op(REQ_READ, 8'd0, 32'h0);
    send_op(REQ_REMOVE_AT, 8'd0, 32'h0);
    send_op(REQ_REMOVE_VALUE, 8'd0, 32'h0);
    // A short list with adjacent duplicates and the extreme words.
    send_op(REQ_APPEND, 8'd255, 32'h0000_0000);
    send_op(REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_op(REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_op(REQ_APPEND, 8'd0, 32'h1234_5678);
    send_op(REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_op(REQ_READ, 8'd0, 32'hFFFF_FFFF);
    send_op(REQ_READ, 8'd3, 32'h0);
    // Reads at and far past the end of the list.
    send_op(REQ_READ, 8'd5, 32'h0);
    send_op(REQ_READ, 8'd255, 32'h0);
    // Removing a value that sits in adjacent entries must take all of them.
    send_op(REQ_REMOVE_VALUE, 8'd0, 32'hFFFF_FFFF);
    send_op(REQ_READ, 8'd1, 32'h0);
    send_op(REQ_REMOVE_AT, 8'd1, 32'h0);
    send_op(REQ_REMOVE_AT, 8'd5, 32'h0);
    send_op(REQ_APPEND, 8'd0, 32'hA5A5_A5A5);
    send_op(REQ_APPEND, 8'd0, 32'h5A5A_5A5A);
    // Removing the head shifts every later entry down.
    send_op(REQ_REMOVE_AT, 8'd0, 32'h0);
    send_op(REQ_READ, 8'd0, 32'h0);
    // Undefined request codes with random fields.
    send_op(REQ_CLEAR + 3'd1, 8'($urandom), $urandom);
    send_op(REQ_CLEAR + 3'd2, 8'($urandom), $urandom);
    send_op(REQ_CLEAR + 3'd3, 8'($urandom), $urandom);
    send_op(REQ_REMOVE_VALUE, 8'd0, 32'hDEAD_BEEF);
    send_op(REQ_CLEAR, 8'd0, 32'h0);
    send_op(REQ_READ, 8'd0, 32'h0);
  endtask

  // Result side: draws a stall for every result and takes one long hold-off
  // when the stimulus asks for it. Each time step assigns the stall once.
  initial begin : result_sink
    int gap;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = draw_gap(rx_quiet_left);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    // The sender pauses here until every owed result has been taken.
    in_valid_i <= 1'b0;
    wait_until_drained();

    // Mixed traffic on a short list. Partway through, the result side holds
    // off for a long stretch while requests keep coming back to back, so the
    // block fills up and has to stall its input.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        rx_hold_req   = 1'b1;
        tx_quiet_left = 12;
      end
      send_req(make_request(50));
    end
    in_valid_i <= 1'b0;
    wait_until_drained();

    // Fill the list to the limit and past it, so that appends get dropped,
    // then work on the full list at its last index.
    send_op(REQ_CLEAR, 8'd0, 32'h0);
    for (int n = 0; n < FILL_APPENDS; n++) begin
      send_op(REQ_APPEND, 8'($urandom), pick_value());
    end
    send_op(REQ_READ, 8'd255, 32'h0);
    send_op(REQ_READ, 8'd0, 32'h0);
    send_op(REQ_REMOVE_AT, 8'd255, 32'h0);
    send_op(REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_op(REQ_APPEND, 8'd0, 32'h0000_0001);

    // Fewer appends now: large compactions over a long list.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_req(make_request(20));
    end
    in_valid_i <= 1'b0;

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
